/* rtl/pste_pkg.sv */
// Package for the paged slot table engine: command codes, status codes,
// table geometry, controller states and the command/status structs. No dependencies.
`timescale 1ns / 1ps
package pste_pkg;

    localparam int SLOTS_PER_PAGE = 8;
    localparam int PAGES          = 8;
    localparam int VALUE_BITS     = 32;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_REMOVE  = 2'd1;
    localparam logic [1:0] CMD_SEARCH  = 2'd2;
    localparam logic [1:0] CMD_COMPACT = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_NOPAGES  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture command and reset the scan state
        logic step;    // advance the scan by one slot
        logic finish;  // apply end-of-command updates
        logic emit;    // place a result in the output register
        logic emit_last;
        logic [1:0] emit_status;
        logic emit_use_slot;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic no_pages;
        logic scan_end;    // current slot is the last one to visit
        logic hit;         // current slot is an insert, search or compact hit
        logic found_any;   // a search hit is held back for reporting
        logic remove_ok;
        logic out_busy;    // output register holds an untaken result
    } dp_stat_t;

endpackage

/* rtl/pste_datapath.sv */
// Datapath of the paged slot table engine: slot store, valid bits,
// scan pointer, counters and the output register. Uses pste_pkg.
`timescale 1ns / 1ps
module pste_datapath
    import pste_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     ctl,
    output dp_stat_t    stat,
    input  logic [1:0]  in_cmd,
    input  logic [31:0] in_value,
    input  logic [5:0]  in_slot,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  out_slot,
    output logic [1:0]  out_status,
    output logic [6:0]  out_items,
    output logic [3:0]  out_pages,
    output logic        out_last
);

    localparam int TOTAL = PAGES * SLOTS_PER_PAGE;
    localparam int IW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int CW    = $clog2(TOTAL + 1);
    localparam int PW    = $clog2(PAGES + 1);

    logic [VALUE_BITS-1:0] mem [TOTAL];
    logic [TOTAL-1:0]      valid_reg, valid_next;
    logic [CW-1:0]         items_reg, items_next;
    logic [PW-1:0]         pages_reg, pages_next;
    logic [IW-1:0]         rd_reg, rd_next;     // scan pointer
    logic [CW-1:0]         wr_reg, wr_next;     // compact write pointer
    logic [1:0]            cmd_reg;
    logic [VALUE_BITS-1:0] key_reg;
    logic [5:0]            rslot_reg;
    logic                  pend_reg, pend_next;           // search hit held back
    logic [IW-1:0]         pend_slot_reg, pend_slot_next;
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic                  rd_live;
    logic                  hit;
    logic                  out_valid_reg;
    logic [5:0]            o_slot_reg;
    logic [1:0]            o_status_reg;
    logic [6:0]            o_items_reg;
    logic [3:0]            o_pages_reg;
    logic                  o_last_reg;
    logic [PW-1:0]         ins_page;
    logic [CW-1:0]         wr_round;

    assign rd_live = valid_reg[rd_reg];

    // hit for the current command at the scan pointer
    always_comb begin
        case (cmd_reg)
            CMD_INSERT:  hit = !rd_live;
            CMD_SEARCH:  hit = rd_live && (rd_data_reg == key_reg);
            CMD_COMPACT: hit = rd_live;
            default:     hit = 1'b0;
        endcase
    end

    assign ins_page = PW'(({{(32-IW){1'b0}}, rd_reg} / SLOTS_PER_PAGE) + 1);
    assign wr_round = CW'((32'(wr_reg) + SLOTS_PER_PAGE - 1) / SLOTS_PER_PAGE);

    assign stat.cmd       = cmd_reg;
    assign stat.no_pages  = (pages_reg == '0);
    assign stat.scan_end  = (32'(rd_reg) == TOTAL - 1);
    assign stat.hit       = hit;
    assign stat.found_any = pend_reg;
    assign stat.remove_ok = (32'(rslot_reg) < TOTAL) && valid_reg[rslot_reg[IW-1:0]];
    assign stat.out_busy  = out_valid_reg && !out_ready;

    // next values of scan and table state
    always_comb begin
        valid_next     = valid_reg;
        items_next     = items_reg;
        pages_next     = pages_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        pend_next      = pend_reg;
        pend_slot_next = pend_slot_reg;
        if (ctl.load) begin
            rd_next   = '0;
            wr_next   = '0;
            pend_next = 1'b0;
        end
        if (ctl.step) begin
            if (hit && cmd_reg == CMD_INSERT) begin
                valid_next[rd_reg] = 1'b1;
                items_next = items_reg + 1'b1;
                if (pages_reg < ins_page)
                    pages_next = ins_page;
            end
            if (hit && cmd_reg == CMD_SEARCH) begin
                pend_next      = 1'b1;
                pend_slot_next = rd_reg;
            end
            if (hit && cmd_reg == CMD_COMPACT) begin
                valid_next[rd_reg] = 1'b0;
                valid_next[wr_reg[IW-1:0]] = 1'b1;
                wr_next = wr_reg + 1'b1;
            end
            if (!stat.scan_end)
                rd_next = rd_reg + 1'b1;
        end
        if (ctl.finish) begin
            if (cmd_reg == CMD_REMOVE) begin
                valid_next[rslot_reg[IW-1:0]] = 1'b0;
                items_next = items_reg - 1'b1;
            end
            if (cmd_reg == CMD_COMPACT)
                pages_next = PW'(wr_round);
        end
    end

    // hold table control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            items_reg <= '0;
            pages_reg <= PW'(1);
        end else begin
            valid_reg <= valid_next;
            items_reg <= items_next;
            pages_reg <= pages_next;
        end
        rd_reg        <= rd_next;
        wr_reg        <= wr_next;
        pend_reg      <= pend_next;
        pend_slot_reg <= pend_slot_next;
        if (ctl.load) begin
            cmd_reg   <= in_cmd;
            key_reg   <= in_value[VALUE_BITS-1:0];
            rslot_reg <= in_slot;
        end
    end

    // write the slot store (insert value or compact move), read ahead at the next pointer
    always_ff @(posedge aclk) begin
        if (ctl.step && hit && cmd_reg == CMD_INSERT)
            mem[rd_reg] <= key_reg;
        else if (ctl.step && hit && cmd_reg == CMD_COMPACT)
            mem[wr_reg[IW-1:0]] <= rd_data_reg;
        rd_data_reg <= mem[rd_next];
    end

    // output register, loaded with counts after this cycle's update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (ctl.emit) begin
            o_slot_reg   <= ctl.emit_use_slot ?
                            ((cmd_reg == CMD_SEARCH) ? 6'(pend_slot_reg) : 6'(rd_reg)) : 6'd0;
            o_status_reg <= ctl.emit_status;
            o_items_reg  <= 7'(items_next);
            o_pages_reg  <= 4'(pages_next);
            o_last_reg   <= ctl.emit_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_slot   = o_slot_reg;
    assign out_status = o_status_reg;
    assign out_items  = o_items_reg;
    assign out_pages  = o_pages_reg;
    assign out_last   = o_last_reg;

`ifndef SYNTH
    a_items_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(items_reg) <= TOTAL) else $error("item count beyond store");
    a_items_match: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(items_reg) == $countones(valid_reg)) else $error("item count drift");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.emit |-> !stat.out_busy) else $error("result overwritten");
`endif

endmodule

/* rtl/pste_ctrl.sv */
// Controller of the paged slot table engine: sequences scans and results.
// Uses pste_pkg.
`timescale 1ns / 1ps
module pste_ctrl
    import pste_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  ctl
);

    state_t state_reg, state_next;

    // advance state
    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_WAIT;
            S_WAIT: begin
                if (!stat.out_busy) begin
                    if (stat.cmd == CMD_REMOVE || stat.no_pages && stat.cmd != CMD_INSERT)
                        state_next = S_IDLE;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!stat.out_busy) begin
                    if (stat.cmd == CMD_INSERT && stat.hit)
                        state_next = S_IDLE;
                    else if (stat.scan_end)
                        state_next = (stat.cmd == CMD_INSERT) ? S_IDLE : S_DONE;
                end
            end
            S_DONE: if (!stat.out_busy) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready = (state_reg == S_IDLE);
        ctl = '0;
        ctl.load = (state_reg == S_IDLE) && in_valid;
        case (state_reg)
            S_WAIT: begin
                if (!stat.out_busy) begin
                    if (stat.no_pages && stat.cmd != CMD_INSERT) begin
                        ctl.emit = 1'b1;
                        ctl.emit_last = 1'b1;
                        ctl.emit_status = ST_NOPAGES;
                    end else if (stat.cmd == CMD_REMOVE) begin
                        ctl.emit = 1'b1;
                        ctl.emit_last = 1'b1;
                        ctl.finish = stat.remove_ok;
                        ctl.emit_status = stat.remove_ok ? ST_OK : ST_NOTFOUND;
                    end
                end
            end
            S_SCAN: begin
                if (!stat.out_busy) begin
                    ctl.step = 1'b1;
                    case (stat.cmd)
                        CMD_INSERT: begin
                            if (stat.hit || stat.scan_end) begin
                                ctl.emit = 1'b1;
                                ctl.emit_last = 1'b1;
                                ctl.emit_use_slot = stat.hit;
                                ctl.emit_status = stat.hit ? ST_OK : ST_FULL;
                            end
                        end
                        CMD_SEARCH: begin
                            // release the held match once a later one turns up
                            if (stat.hit && stat.found_any) begin
                                ctl.emit = 1'b1;
                                ctl.emit_use_slot = 1'b1;
                                ctl.emit_status = ST_OK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DONE: begin
                // final search match, not found, or compact result
                if (!stat.out_busy) begin
                    ctl.finish = 1'b1;
                    ctl.emit = 1'b1;
                    ctl.emit_last = 1'b1;
                    ctl.emit_use_slot = (stat.cmd == CMD_SEARCH) && stat.found_any;
                    ctl.emit_status = (stat.cmd == CMD_SEARCH && !stat.found_any) ?
                                      ST_NOTFOUND : ST_OK;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load |=> state_reg == S_WAIT) else $error("load without wait");
    a_step_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.step |-> state_reg == S_SCAN) else $error("step outside scan");
    a_done_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && !stat.out_busy) |-> ctl.emit && ctl.emit_last)
        else $error("final result lost");
`endif

endmodule

/* rtl/paged_slot_table_engine_top.sv */
// Paged slot table engine: insert, remove, search and compact over a slot table.
// Remove and no-pages results need no scan; insert scans one slot per cycle while no result
// waits, stopping at the first free slot; search and compact visit every slot.
// Throughput: one command at a time; a search match is held until the next match or the
// end of the scan, then matches leave at most one per cycle; a waiting result stalls the scan.
// Reset (aresetn low, synchronous) clears valid bits, item count, sets one page.
`timescale 1ns / 1ps
module paged_slot_table_engine_top
    import pste_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // cmd[1:0], value[33:2], slot[39:34]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // slot_out[5:0], status[7:6], item_count[14:8],
                                  // page_count[18:15], zero fill
    output logic        m_tlast
);

    dp_cmd_t  ctl;
    dp_stat_t stat;
    logic [5:0] o_slot;
    logic [1:0] o_status;
    logic [6:0] o_items;
    logic [3:0] o_pages;

    pste_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .stat(stat), .ctl(ctl)
    );

    pste_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .stat(stat),
        .in_cmd(s_tdata[1:0]), .in_value(s_tdata[33:2]), .in_slot(s_tdata[39:34]),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_slot(o_slot), .out_status(o_status), .out_items(o_items),
        .out_pages(o_pages), .out_last(m_tlast)
    );

    assign m_tdata = {5'd0, o_pages, o_items, o_status, o_slot};

endmodule

/* test/tb_paged_slot_table_engine_top.sv */
// Self-checking bench for the paged slot table engine: insert, remove, search and
// compact commands are streamed in, and every result transfer is checked against a
// local slot-table predictor. Depends on pste_pkg and paged_slot_table_engine_top.
`timescale 1ns / 1ps
module tb_paged_slot_table_engine_top;
    import pste_pkg::*;

    localparam int NSLOTS   = 64;
    localparam int WDOG_MAX = 20000;

    typedef struct packed {
        logic [5:0] slot_out;
        logic [1:0] status;
        logic [6:0] item_count;
        logic [3:0] page_count;
        logic       last;
    } table_result_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] value;
        logic [5:0]  slot;
    } table_cmd_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    paged_slot_table_engine_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    // predictor state
    logic [31:0]   pred_value [NSLOTS];
    logic          pred_live  [NSLOTS];
    int            pred_items;
    int            pred_pages;
    table_result_t expected_results[$];
    table_cmd_t    pending_cmds[$];

    int  error_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  recv_hold = 1'b0;
    bit  send_hold = 1'b0;
    int  idle_cycles = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic table_result_t make_result(input int slot_n, input logic [1:0] st,
                                                  input bit is_last);
        table_result_t r;
        r.slot_out = slot_n[5:0];
        r.status = st;
        r.item_count = pred_items[6:0];
        r.page_count = pred_pages[3:0];
        r.last = is_last;
        return r;
    endfunction

    // apply one command to the predictor and queue its results
    task automatic predict_table(input table_cmd_t c);
        int hits[$];
        int w;
        if (c.cmd == CMD_INSERT) begin
            for (int i = 0; i < NSLOTS; i++) begin
                if (!pred_live[i]) begin
                    pred_value[i] = c.value;
                    pred_live[i] = 1'b1;
                    pred_items++;
                    if (pred_pages < i / 8 + 1) pred_pages = i / 8 + 1;
                    expected_results.push_back(make_result(i, ST_OK, 1'b1));
                    return;
                end
            end
            expected_results.push_back(make_result(0, ST_FULL, 1'b1));
        end else if (pred_pages == 0) begin
            expected_results.push_back(make_result(0, ST_NOPAGES, 1'b1));
        end else if (c.cmd == CMD_REMOVE) begin
            if (pred_live[c.slot]) begin
                pred_live[c.slot] = 1'b0;
                pred_items--;
                expected_results.push_back(make_result(0, ST_OK, 1'b1));
            end else begin
                expected_results.push_back(make_result(0, ST_NOTFOUND, 1'b1));
            end
        end else if (c.cmd == CMD_SEARCH) begin
            for (int i = 0; i < NSLOTS; i++)
                if (pred_live[i] && pred_value[i] == c.value) hits.push_back(i);
            if (hits.size() == 0)
                expected_results.push_back(make_result(0, ST_NOTFOUND, 1'b1));
            foreach (hits[k])
                expected_results.push_back(make_result(hits[k], ST_OK, k == hits.size() - 1));
        end else begin
            w = 0;
            for (int i = 0; i < NSLOTS; i++) begin
                if (pred_live[i]) begin
                    pred_value[w] = pred_value[i];
                    pred_live[i] = 1'b0;
                    pred_live[w] = 1'b1;
                    w++;
                end
            end
            pred_pages = (w + 7) / 8;
            expected_results.push_back(make_result(0, ST_OK, 1'b1));
        end
    endtask

    // driver: offer pending commands, predict on each accepted transfer
    always @(posedge aclk) begin
        table_cmd_t c;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                c.cmd = s_tdata[1:0];
                c.value = s_tdata[33:2];
                c.slot = s_tdata[39:34];
                predict_table(c);
            end
            if ((!s_tvalid || s_tready) ) begin
                if (pending_cmds.size() > 0 && !send_hold &&
                    $urandom_range(99) >= send_idle_pct) begin
                    c = pending_cmds.pop_front();
                    s_tdata <= {c.slot, c.value, c.cmd};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result transfer, randomise ready
    always @(posedge aclk) begin
        table_result_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[5:0], m_tdata[7:6], m_tdata[14:8], m_tdata[18:15], m_tlast};
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, slot_out", got.slot_out, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (got.slot_out !== want.slot_out)
                        report_mismatch("slot_out", got.slot_out, want.slot_out);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.item_count !== want.item_count)
                        report_mismatch("item_count", got.item_count, want.item_count);
                    if (got.page_count !== want.page_count)
                        report_mismatch("page_count", got.page_count, want.page_count);
                    if (got.last !== want.last)
                        report_mismatch("last", got.last, want.last);
                end
            end
            m_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: count cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else if (aresetn) idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic table_cmd_t mk(input logic [1:0] op, input logic [31:0] v,
                                      input logic [5:0] s);
        table_cmd_t c;
        c.cmd = op;
        c.value = v;
        c.slot = s;
        return c;
    endfunction

    // small value pool so searches hit; a few fully random values too
    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom();
            1: return {$urandom_range(1) ? 32'h8000_0000 : 32'h0} | $urandom_range(3);
            default: return 32'(5 + $urandom_range(3));
        endcase
    endfunction

    function automatic table_cmd_t random_cmd(input int fill_bias);
        int r;
        r = $urandom_range(99);
        if (r < fill_bias) return mk(CMD_INSERT, pick_value(), 6'($urandom()));
        if (r < fill_bias + 20) return mk(CMD_REMOVE, $urandom(), 6'($urandom()));
        if (r < 95) return mk(CMD_SEARCH, pick_value(), 6'($urandom()));
        return mk(CMD_COMPACT, $urandom(), 6'($urandom()));
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic run_phase(input int n, input int send_pct, input int recv_pct,
                             input int fill_bias);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < n; i++) pending_cmds.push_back(random_cmd(fill_bias));
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table cases, extremes, no-pages after compact
        pending_cmds.push_back(mk(CMD_SEARCH, 32'h0, 6'd0));
        pending_cmds.push_back(mk(CMD_REMOVE, 32'hFFFF_FFFF, 6'd63));
        pending_cmds.push_back(mk(CMD_COMPACT, 32'h0, 6'd0));
        pending_cmds.push_back(mk(CMD_REMOVE, 32'h0, 6'd0));
        pending_cmds.push_back(mk(CMD_SEARCH, 32'h0, 6'd0));
        pending_cmds.push_back(mk(CMD_COMPACT, 32'h0, 6'd0));
        pending_cmds.push_back(mk(CMD_INSERT, 32'h8000_0000, 6'd63));
        pending_cmds.push_back(mk(CMD_INSERT, 32'h7FFF_FFFF, 6'd0));
        pending_cmds.push_back(mk(CMD_INSERT, 32'h8000_0000, 6'd0));
        pending_cmds.push_back(mk(CMD_SEARCH, 32'h8000_0000, 6'd63));
        pending_cmds.push_back(mk(CMD_REMOVE, 32'h0, 6'd0));
        pending_cmds.push_back(mk(CMD_REMOVE, 32'h0, 6'd0));
        pending_cmds.push_back(mk(CMD_COMPACT, 32'h0, 6'd0));
        pending_cmds.push_back(mk(CMD_SEARCH, 32'hFFFF_FFFF, 6'd0));
        wait_drained();

        // fill past full with one repeated value, then search returns many hits
        for (int i = 0; i < 66; i++) pending_cmds.push_back(mk(CMD_INSERT, 32'd7, 6'd0));
        pending_cmds.push_back(mk(CMD_SEARCH, 32'd7, 6'd0));
        pending_cmds.push_back(mk(CMD_REMOVE, 32'h0, 6'd63));
        pending_cmds.push_back(mk(CMD_REMOVE, 32'h0, 6'd9));
        pending_cmds.push_back(mk(CMD_COMPACT, 32'h0, 6'd0));
        wait_drained();

        run_phase(50, 0, 0, 45);
        run_phase(52, 86, 0, 40);
        run_phase(52, 0, 86, 40);
        run_phase(52, 9, 9, 35);

        // long receiver hold-off while the sender keeps offering
        recv_hold = 1'b1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 30; i++) pending_cmds.push_back(random_cmd(40));
        repeat (300) @(posedge aclk);
        recv_hold = 1'b0;
        wait_drained();

        // sender pause with results in flight, held until all have come back
        for (int i = 0; i < 40; i++) pending_cmds.push_back(random_cmd(40));
        repeat (20) @(posedge aclk);
        send_hold = 1'b1;
        while (expected_results.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        send_hold = 1'b0;
        wait_drained();
        run_phase(20, 30, 30, 30);

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        for (int i = 0; i < NSLOTS; i++) begin
            pred_live[i] = 1'b0;
            pred_value[i] = '0;
        end
        pred_items = 0;
        pred_pages = 1;
    end
endmodule
